/* rtl/core/reward_gated_hebbian_update_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the reward gated Hebbian update core
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REWARD_GATED_HEBBIAN_UPDATE_CORE_ASSERT_SVH
`define REWARD_GATED_HEBBIAN_UPDATE_CORE_ASSERT_SVH

// same-cycle implication
`define RGHU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGHU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rghu_pkg.sv */
// ----------------------------------------------------------------------------
// rghu_pkg
// Types and constants shared by the reward gated Hebbian update core.
// ----------------------------------------------------------------------------
`default_nettype none

package rghu_pkg;

  // Q format of activations, weights and thresholds
  localparam int FRAC_BITS = 12;

  // readout gate opens above one half
  localparam logic signed [15:0] READOUT_LEVEL = 16'(1 << (FRAC_BITS - 1));

  localparam logic [12:0] TALLY_MAX = 13'h1FFF;

  // item kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ASSOC  = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_DURATION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_DUR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS    = 3'd6;

  typedef struct packed {
    logic        [15:0] learn_rate;
    logic signed [15:0] reward_threshold;
    logic               use_reward_duration;
    logic        [23:0] reward_duration;
    logic        [14:0] match_threshold;
    logic        [6:0]  active_rows;
    logic        [6:0]  active_cols;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_ADJ,
    ST_MUL2,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic take;
    logic mul1;
    logic adj;
    logic mul2;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic assoc_hit;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/core/rghu_in_if.sv */
// ----------------------------------------------------------------------------
// rghu_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rghu_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [15:0] reward_sum;
  logic        [15:0] step_time;
  logic signed [15:0] readout_value;
  logic        [5:0]  row;
  logic        [5:0]  col;
  logic signed [15:0] value;

  modport source (
    output valid, kind, reward_sum, step_time, readout_value, row, col, value,
    input  ready
  );
  modport sink (
    input  valid, kind, reward_sum, step_time, readout_value, row, col, value,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rghu_out_if.sv */
// ----------------------------------------------------------------------------
// rghu_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rghu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] weight_out;
  logic        [12:0] match_count;
  logic               last;

  modport source (
    output valid, weight_out, match_count, last,
    input  ready
  );
  modport sink (
    input  valid, weight_out, match_count, last,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rghu_cfg_if.sv */
// ----------------------------------------------------------------------------
// rghu_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rghu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rghu_cfg.sv */
// ----------------------------------------------------------------------------
// rghu_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rghu_cfg import rghu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_LEARN_RATE:    cfg_nxt.learn_rate          = wr_data[15:0];
        CFG_REWARD_THRESH: cfg_nxt.reward_threshold    = signed'(wr_data[15:0]);
        CFG_USE_DURATION:  cfg_nxt.use_reward_duration = wr_data[0];
        CFG_REWARD_DUR:    cfg_nxt.reward_duration     = wr_data[23:0];
        CFG_MATCH_THRESH:  cfg_nxt.match_threshold     = wr_data[14:0];
        CFG_ACTIVE_ROWS:   cfg_nxt.active_rows         = wr_data[6:0];
        CFG_ACTIVE_COLS:   cfg_nxt.active_cols         = wr_data[6:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate          <= 16'd66;
      cfg_r.reward_threshold    <= 16'sd2048;
      cfg_r.use_reward_duration <= 1'b0;
      cfg_r.reward_duration     <= 24'd3200;
      cfg_r.match_threshold     <= 15'd2048;
      cfg_r.active_rows         <= 7'd50;
      cfg_r.active_cols         <= 7'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/rghu_ctrl.sv */
// ----------------------------------------------------------------------------
// rghu_ctrl
// Sequencer: memory clear after reset, then per-item step control.
// ----------------------------------------------------------------------------
`default_nettype none

module rghu_ctrl import rghu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && sts.assoc_hit) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_ADJ;
      ST_ADJ:   state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_EMIT;
      ST_EMIT:  if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MUL1:  cmd.mul1 = 1'b1;
      ST_ADJ:   cmd.adj  = 1'b1;
      ST_MUL2:  cmd.mul2 = 1'b1;
      ST_EMIT:  cmd.emit = !sts.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rghu_dp.sv */
// ----------------------------------------------------------------------------
// rghu_dp
// Datapath: weight memory, reward window state, update and match arithmetic,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rghu_dp import rghu_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic        [1:0]  in_kind,
  input  logic signed [15:0] in_reward_sum,
  input  logic        [15:0] in_step_time,
  input  logic signed [15:0] in_readout_value,
  input  logic        [5:0]  in_row,
  input  logic        [5:0]  in_col,
  input  logic signed [15:0] in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_weight_out,
  output logic        [12:0] out_match_count,
  output logic               out_last
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_W = 9;
  localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(MAX_COLS);

  // --- element decode ---
  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic             hit;
  logic             is_last;
  logic [15:0]      addr_full;
  logic [AW-1:0]    addr;

  always_comb begin
    rows = (DIM_W'(cfg.active_rows) < ROWS_MAX) ? DIM_W'(cfg.active_rows) : ROWS_MAX;
    cols = (DIM_W'(cfg.active_cols) < COLS_MAX) ? DIM_W'(cfg.active_cols) : COLS_MAX;
    hit  = (DIM_W'(in_row) < rows) && (DIM_W'(in_col) < cols);
    is_last = (DIM_W'(in_row) == rows - DIM_W'(1)) && (DIM_W'(in_col) == cols - DIM_W'(1));
    addr_full = 16'(in_row) * 16'(MAX_COLS) + 16'(in_col);
    addr = addr_full[AW-1:0];
  end

  logic take_hdr;
  logic take_load;
  assign take_hdr  = cmd.take && (in_kind == KIND_HEADER);
  assign take_load = cmd.take && (in_kind == KIND_LOAD) && hit;

  // --- reward window state ---
  logic [31:0] elapsed_r;
  logic        rewarded_r;
  logic        learn_r;
  logic        readout_r;
  logic [12:0] tally_r;

  logic        reward_on;
  logic        restart;
  logic [31:0] elapsed_base;
  logic [32:0] elapsed_sum;
  logic [31:0] elapsed_sat;

  always_comb begin
    reward_on    = in_reward_sum > cfg.reward_threshold;
    restart      = !rewarded_r && cfg.use_reward_duration;
    elapsed_base = restart ? 32'd0 : elapsed_r;
    elapsed_sum  = 33'(elapsed_base) + 33'(in_step_time);
    elapsed_sat  = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
  end

  // --- item registers ---
  logic signed [15:0] a_r;
  logic [AW-1:0]      addr_r;
  logic               last_r;
  logic signed [15:0] rdata_r;
  logic signed [33:0] p_r;
  logic signed [15:0] w_new_r;
  logic signed [31:0] prod_r;
  logic [AW-1:0]      clr_cnt_r;

  logic signed [16:0] diff;
  logic signed [16:0] lr_s;
  logic signed [34:0] rounded;
  logic signed [18:0] delta;
  logic signed [19:0] wsum;
  logic signed [15:0] wsat;

  always_comb begin
    diff    = 17'(a_r) - 17'(rdata_r);
    lr_s    = signed'({1'b0, cfg.learn_rate});
    rounded = 35'(p_r) + 35'sd32768;
    delta   = rounded[34:16];  // floor shift: round half up
    wsum    = 20'(rdata_r) + 20'(delta);
    if (wsum > 20'sd32767) begin
      wsat = 16'sh7FFF;
    end else if (wsum < -20'sd32768) begin
      wsat = 16'sh8000;
    end else begin
      wsat = wsum[15:0];
    end
  end

  // --- match test ---
  logic signed [33:0] match_thr;
  logic               is_match;
  logic [12:0]        tally_nxt;

  always_comb begin
    match_thr = signed'(34'(cfg.match_threshold) << FRAC_BITS);
    is_match  = 34'(prod_r) >= match_thr;
    tally_nxt = (is_match && (tally_r != TALLY_MAX)) ? tally_r + 13'd1 : tally_r;
  end

  // --- weight memory ---
  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_cnt_r] <= '0;
    end else if (take_load) begin
      mem[addr] <= in_value;
    end else if (cmd.adj && learn_r) begin
      mem[addr_r] <= wsat;
    end
    if (cmd.take) begin
      rdata_r <= mem[addr];
    end
  end

  // --- payload pipeline ---
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      a_r    <= in_value;
      addr_r <= addr;
      last_r <= is_last;
    end
    if (cmd.mul1) begin
      p_r <= lr_s * diff;
    end
    if (cmd.adj) begin
      w_new_r <= learn_r ? wsat : rdata_r;
    end
    if (cmd.mul2) begin
      prod_r <= a_r * w_new_r;
    end
  end

  // --- control state ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      elapsed_r  <= '0;
      rewarded_r <= 1'b0;
      learn_r    <= 1'b0;
      readout_r  <= 1'b0;
      tally_r    <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (take_hdr) begin
        if (reward_on) begin
          if (restart) begin
            rewarded_r <= 1'b1;
          end
          elapsed_r <= elapsed_sat;
          learn_r   <= (elapsed_sat < 32'(cfg.reward_duration)) || !cfg.use_reward_duration;
        end else begin
          learn_r <= 1'b0;
          if (cfg.use_reward_duration) begin
            rewarded_r <= 1'b0;
          end
        end
        readout_r <= in_readout_value > READOUT_LEVEL;
        tally_r   <= '0;
      end else if (cmd.emit) begin
        tally_r <= tally_nxt;
      end
    end
  end

  // --- result register ---
  logic               out_valid_r;
  logic signed [15:0] out_weight_r;
  logic [12:0]        out_count_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_weight_r <= readout_r ? w_new_r : 16'sd0;
      out_count_r  <= tally_nxt;
      out_last_r   <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_weight_out  = out_weight_r;
  assign out_match_count = out_count_r;
  assign out_last        = out_last_r;

  assign sts.clear_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.assoc_hit  = (in_kind == KIND_ASSOC) && hit;
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

`default_nettype wire

/* rtl/core/reward_gated_hebbian_update_core.sv */
// ----------------------------------------------------------------------------
// reward_gated_hebbian_update_core
// Reward gated Hebbian learning over a weight matrix held in on-chip memory.
// ----------------------------------------------------------------------------
// After reset the core zeroes its weight memory, one entry per cycle, over
// all MAX_ROWS*MAX_COLS entries (4096 at the defaults); input ready stays low
// during that pass while configuration writes are taken as usual. Header,
// weight load, out-of-range and unused items are then taken without leaving
// the idle state. An association element passes through memory read at
// acceptance, the learning-rate multiply, the weight adjust and write-back,
// the match multiply and the result register load; the result register lets
// the next item be accepted while a result still waits, and a stalled result
// holds the next association element with input ready low. Configuration is
// written by the user while the core is idle; the core does not enforce it.
`default_nettype none

module reward_gated_hebbian_update_core import rghu_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  rghu_in_if.sink      in_ch,
  rghu_out_if.source   out_ch,
  rghu_cfg_if.sink     cfg_ch
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rghu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  rghu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rghu_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_ch.kind),
    .in_reward_sum    (in_ch.reward_sum),
    .in_step_time     (in_ch.step_time),
    .in_readout_value (in_ch.readout_value),
    .in_row           (in_ch.row),
    .in_col           (in_ch.col),
    .in_value         (in_ch.value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_weight_out   (out_ch.weight_out),
    .out_match_count  (out_ch.match_count),
    .out_last         (out_ch.last)
  );

endmodule

`default_nettype wire

/* rtl/core/rghu_chk.sv */
// ----------------------------------------------------------------------------
// rghu_chk
// Port-level checks for the reward gated Hebbian update core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reward_gated_hebbian_update_core_assert.svh"

module rghu_chk import rghu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic        [1:0]  in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_weight_out,
  input logic        [12:0] out_match_count,
  input logic               out_last
);

  // a stalled result holds
  `RGHU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight_out) && $stable(out_match_count) && $stable(out_last), "result changed while stalled")

  // headers finish in the cycle they are taken
  `RGHU_ASSERT_NXT(a_hdr_single, in_valid && in_ready && (in_kind == KIND_HEADER), in_ready, "not ready after header transaction")

  // memory clear runs right after reset release
  `RGHU_ASSERT_IMP(a_clear_first, $rose(rst_n), !in_ready, "input taken before memory clear")

endmodule

bind reward_gated_hebbian_update_core rghu_chk u_rghu_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_weight_out  (out_ch.weight_out),
  .out_match_count (out_ch.match_count),
  .out_last        (out_ch.last)
);

`default_nettype wire

/* tb/tb_reward_gated_hebbian_update_core.sv */
// ----------------------------------------------------------------------------
// tb_reward_gated_hebbian_update_core
// Self-checking bench: drives tick headers, association and weight load
// elements through the input channel, tracks the weight matrix and the reward
// window in a scoreboard, and compares every result transaction against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_reward_gated_hebbian_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rghu_pkg::*;

  localparam int N_ROWS = 64;
  localparam int N_COLS = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] reward_sum;
    logic        [15:0] step_time;
    logic signed [15:0] readout_value;
    logic        [5:0]  row;
    logic        [5:0]  col;
    logic signed [15:0] value;
  } hebb_item_t;

  typedef struct packed {
    logic signed [15:0] weight;
    logic        [12:0] count;
    logic               last;
  } assoc_result_t;

  // Tracks weights, reward window and match tally; queues expected results.
  class weight_update_tracker;
    logic        [15:0] learn_rate;
    logic signed [15:0] reward_thr;
    logic               use_window;
    logic        [23:0] window_len;
    logic        [14:0] match_thr;
    logic        [6:0]  rows;
    logic        [6:0]  cols;
    logic signed [15:0] weights [N_ROWS*N_COLS];
    logic        [31:0] elapsed;
    logic               rewarded;
    logic               learning;
    logic               readout_open;
    logic        [12:0] tally;
    assoc_result_t      expected_updates[$];
    int                 errors;

    function new();
      learn_rate   = 16'd66;
      reward_thr   = 16'sd2048;
      use_window   = 1'b0;
      window_len   = 24'd3200;
      match_thr    = 15'd2048;
      rows         = 7'd50;
      cols         = 7'd50;
      foreach (weights[i]) weights[i] = '0;
      elapsed      = '0;
      rewarded     = 1'b0;
      learning     = 1'b0;
      readout_open = 1'b0;
      tally        = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        CFG_LEARN_RATE:    learn_rate = data[15:0];
        CFG_REWARD_THRESH: reward_thr = $signed(data[15:0]);
        CFG_USE_DURATION:  use_window = data[0];
        CFG_REWARD_DUR:    window_len = data;
        CFG_MATCH_THRESH:  match_thr = data[14:0];
        CFG_ACTIVE_ROWS:   rows = data[6:0];
        CFG_ACTIVE_COLS:   cols = data[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction

    // returns 1 unless the item is ignored by the core
    function bit take_item(hebb_item_t it);
      int            nrows;
      int            ncols;
      int            addr;
      int            a;
      int            w;
      longint        p;
      longint        delta;
      longint        prod;
      logic   [32:0] sum;
      assoc_result_t r;
      nrows = (rows < N_ROWS) ? int'(rows) : N_ROWS;
      ncols = (cols < N_COLS) ? int'(cols) : N_COLS;
      if (it.kind == KIND_HEADER) begin
        if ($signed(it.reward_sum) > reward_thr) begin
          if (!rewarded && use_window) begin
            elapsed  = '0;
            rewarded = 1'b1;
          end
          sum = {1'b0, elapsed} + {17'd0, it.step_time};
          elapsed = sum[32] ? '1 : sum[31:0];
          learning = (elapsed < {8'd0, window_len}) || !use_window;
        end else begin
          learning = 1'b0;
          if (use_window) rewarded = 1'b0;
        end
        readout_open = $signed(it.readout_value) > READOUT_LEVEL;
        tally = '0;
        return 1'b1;
      end
      if (it.kind != KIND_ASSOC && it.kind != KIND_LOAD) return 1'b0;
      if (int'(it.row) >= nrows || int'(it.col) >= ncols) return 1'b0;
      addr = int'(it.row) * N_COLS + int'(it.col);
      if (it.kind == KIND_LOAD) begin
        weights[addr] = $signed(it.value);
        return 1'b1;
      end
      a = int'($signed(it.value));
      w = int'(weights[addr]);
      if (learning) begin
        p = longint'(learn_rate) * longint'(a - w);
        delta = (p + 64'sd32768) >>> 16;
        w = w + int'(delta);
        if (w > 32767) w = 32767;
        else if (w < -32768) w = -32768;
        weights[addr] = 16'(w);
      end
      prod = longint'(a) * longint'(w);
      if (prod >= (longint'(match_thr) <<< FRAC_BITS) && tally != TALLY_MAX) tally++;
      r.weight = readout_open ? 16'(w) : '0;
      r.count  = tally;
      r.last   = (int'(it.row) == nrows - 1) && (int'(it.col) == ncols - 1);
      expected_updates.insert(expected_updates.size(), r);
      return 1'b1;
    endfunction

    function void check_result(logic [15:0] weight, logic [12:0] count, logic last);
      assoc_result_t want;
      if (expected_updates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result weight_out %0d match_count %0d last %0b",
                 $time, $signed(weight), count, last);
        return;
      end
      want = expected_updates.pop_front();
      if (weight !== want.weight) begin
        errors++;
        $display("%0t: weight_out expected %0d actual %0d", $time, $signed(want.weight),
                 $signed(weight));
      end
      if (count !== want.count) begin
        errors++;
        $display("%0t: match_count expected %0d actual %0d", $time, want.count, count);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   live_items;

  weight_update_tracker tracker;

  rghu_in_if  in_bus();
  rghu_out_if out_bus();
  rghu_cfg_if cfg_bus();

  reward_gated_hebbian_update_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check each accepted transaction, then pick next ready
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready)
        tracker.check_result(out_bus.weight_out, out_bus.match_count, out_bus.last);
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #8ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic hebb_item_t rand_item();
    hebb_item_t it;
    it.kind          = 2'($urandom);
    it.reward_sum    = 16'($urandom);
    it.step_time     = 16'($urandom);
    it.readout_value = 16'($urandom);
    it.row           = 6'($urandom);
    it.col           = 6'($urandom);
    it.value         = 16'($urandom);
    return it;
  endfunction

  function automatic hebb_item_t hdr(logic [15:0] rs, logic [15:0] st, logic [15:0] ro);
    hebb_item_t it;
    it = rand_item();
    it.kind          = KIND_HEADER;
    it.reward_sum    = rs;
    it.step_time     = st;
    it.readout_value = ro;
    return it;
  endfunction

  function automatic hebb_item_t elem(logic [1:0] kind, int r, int c, logic [15:0] v);
    hebb_item_t it;
    it = rand_item();
    it.kind  = kind;
    it.row   = 6'(r);
    it.col   = 6'(c);
    it.value = v;
    return it;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h1000;
          default: return 16'hF000;
        endcase
      end
      default: return 16'($urandom_range(16384) - 8192);
    endcase
  endfunction

  task automatic send(hebb_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= it.kind;
    in_bus.reward_sum    <= it.reward_sum;
    in_bus.step_time     <= it.step_time;
    in_bus.readout_value <= it.readout_value;
    in_bus.row           <= it.row;
    in_bus.col           <= it.col;
    in_bus.value         <= it.value;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (tracker.take_item(it)) live_items++;
  endtask

  task automatic element(int r, int c);
    if ($urandom_range(9) == 0) send(elem(KIND_LOAD, r, c, rand_value()));
    send(elem(KIND_ASSOC, r, c, rand_value()));
  endtask

  task automatic sweep();
    int nr;
    int nc;
    nr = (tracker.rows < N_ROWS) ? int'(tracker.rows) : N_ROWS;
    nc = (tracker.cols < N_COLS) ? int'(tracker.cols) : N_COLS;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) element(r, c);
  endtask

  // sender parks until every outstanding result is back, then the core settles
  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    tracker.write_reg(idx, data);
  endtask

  // unused upper data bits carry junk on purpose
  task automatic set_config(logic [15:0] lr, logic [15:0] thr, logic use_dur,
                            logic [23:0] dur, logic [14:0] mthr,
                            logic [6:0] rows, logic [6:0] cols);
    wait_drain();
    write_reg(CFG_LEARN_RATE, {8'($urandom), lr});
    write_reg(CFG_REWARD_THRESH, {8'($urandom), thr});
    write_reg(CFG_USE_DURATION, {23'($urandom), use_dur});
    write_reg(CFG_REWARD_DUR, dur);
    write_reg(CFG_MATCH_THRESH, {9'($urandom), mthr});
    write_reg(CFG_ACTIVE_ROWS, {17'($urandom), rows});
    write_reg(CFG_ACTIVE_COLS, {17'($urandom), cols});
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 60; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 60; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  // mostly well-formed ticks (header, then elements), some random noise
  task automatic run_ticks(int n_live);
    int          goal;
    int          nr;
    int          nc;
    logic [15:0] rs;
    logic [15:0] st;
    logic [15:0] ro;
    goal = live_items + n_live;
    while (live_items < goal) begin
      nr = (tracker.rows < N_ROWS) ? int'(tracker.rows) : N_ROWS;
      nc = (tracker.cols < N_COLS) ? int'(tracker.cols) : N_COLS;
      if ($urandom_range(9) < 8) begin
        rs = $urandom_range(1) ? 16'(int'(tracker.reward_thr) + int'($urandom_range(8)) - 4)
                               : 16'($urandom);
        st = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400));
        ro = $urandom_range(1) ? 16'($urandom_range(32767, 2049)) : 16'($urandom);
        send(hdr(rs, st, ro));
        if (nr * nc <= 48) begin
          sweep();
        end else begin
          repeat ($urandom_range(30, 10)) element($urandom_range(nr - 1), $urandom_range(nc - 1));
          element(nr - 1, nc - 1);
        end
      end else begin
        repeat ($urandom_range(4, 1)) send(rand_item());
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = KIND_HEADER;
    in_bus.reward_sum    = '0;
    in_bus.step_time     = '0;
    in_bus.readout_value = '0;
    in_bus.row           = '0;
    in_bus.col           = '0;
    in_bus.value         = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = CFG_LEARN_RATE;
    cfg_bus.data         = '0;
    idle_pct             = 0;
    stall_pct            = 0;
    live_items           = 0;
    tracker              = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, gate edges, ignored items
    set_idle(0);
    set_config(16'hFFFF, 16'd2048, 1'b0, 24'd3200, 15'd0, 7'd2, 7'd3);
    send(elem(KIND_LOAD, 0, 0, 16'h7FFF));
    send(elem(KIND_LOAD, 0, 1, 16'h8000));
    send(elem(KIND_LOAD, 1, 2, 16'h1000));
    send(hdr(16'h7FFF, 16'hFFFF, 16'h7FFF));
    send(elem(KIND_ASSOC, 0, 0, 16'h8000));
    send(elem(KIND_ASSOC, 0, 1, 16'h7FFF));
    send(elem(KIND_ASSOC, 1, 2, 16'h1000));
    send(elem(KIND_ASSOC, 1, 1, 16'hF000));
    // reward and readout exactly at their levels: both gates stay shut
    send(hdr(16'd2048, 16'd0, 16'd2048));
    send(elem(KIND_ASSOC, 0, 0, 16'h7FFF));
    send(hdr(16'd2049, 16'd1, 16'd2049));
    send(elem(KIND_ASSOC, 1, 2, 16'hFFFF));
    send(elem(KIND_ASSOC, 2, 0, 16'h1234));
    send(elem(KIND_ASSOC, 0, 3, 16'h1234));
    send(elem(KIND_LOAD, 63, 63, 16'h7FFF));
    send(hebb_item_t'({KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F, 6'h3F, 16'hFFFF}));
    send(hdr(16'h8000, 16'd0, 16'h8000));
    send(elem(KIND_ASSOC, 1, 0, 16'h0000));
    send(elem(KIND_ASSOC, 0, 2, 16'h8000));

    // reward window runs out under continued reward; learning must stay off
    set_config(16'd30000, 16'd0, 1'b1, 24'd1000, 15'd0, 7'd2, 7'd2);
    send(hdr(16'h7FFF, 16'd0, 16'h7FFF));
    sweep();
    repeat (3) send(hdr(16'h7FFF, 16'd400, 16'h7FFF));
    sweep();

    set_config(16'($urandom), 16'd0, 1'b0, 24'd3200, 15'd2048, 7'd4, 7'd5);
    set_idle(0);
    run_ticks(300);

    set_config(16'hFFFF, 16'd2048, 1'b1, 24'd0, 15'd4096, 7'd1, 7'd1);
    set_idle(1);
    run_ticks(150);

    set_config(16'h0000, 16'h8000, 1'b0, 24'hFFFFFF, 15'd0, 7'd64, 7'd64);
    set_idle(2);
    run_ticks(250);

    set_config(16'($urandom), 16'd1000, 1'b1, 24'd1500, 15'h7FFF, 7'd7, 7'd3);
    set_idle(3);
    run_ticks(350);

    set_config(16'd4000, 16'h7FFF, 1'b1, 24'($urandom), 15'($urandom), 7'd3, 7'd8);
    set_idle(1);
    run_ticks(150);

    for (int k = 0; k < 4; k++) begin
      set_config(16'($urandom), 16'(int'($urandom_range(12000)) - 6000),
                 1'($urandom), 24'($urandom_range(4000)),
                 $urandom_range(1) ? 15'($urandom_range(8192)) : 15'($urandom),
                 7'($urandom_range(8, 1)), 7'($urandom_range(8, 1)));
      set_idle(k);
      run_ticks(190);
    end

    wait_drain();
    repeat (30) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/rghu_pkg.sv
rtl/core/rghu_in_if.sv
rtl/core/rghu_out_if.sv
rtl/core/rghu_cfg_if.sv
rtl/core/rghu_cfg.sv
rtl/core/rghu_ctrl.sv
rtl/core/rghu_dp.sv
rtl/core/reward_gated_hebbian_update_core.sv
rtl/core/rghu_chk.sv
tb/tb_reward_gated_hebbian_update_core.sv
